### design/gpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Game clock package
// Event and status codes, clock state record, reset constants and saturating time arithmetic.
// ----------------------------------------------------------------------------
package gpc_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned MovesW = 16;
  localparam int unsigned ErrW   = 8;
  localparam int unsigned OpW    = 3;
  localparam int unsigned StatW  = 3;

  localparam logic [TimeW-1:0] START_TIME_RST = TimeW'(300000);
  localparam logic [TimeW-1:0] INCREMENT_RST  = '0;
  localparam logic [ErrW-1:0]  ERROR_LIMIT    = ErrW'(2);

  localparam logic [OpW-1:0] OP_TICK        = 3'd0;
  localparam logic [OpW-1:0] OP_PRESS       = 3'd1;
  localparam logic [OpW-1:0] OP_PAUSE       = 3'd2;
  localparam logic [OpW-1:0] OP_ARB_STOP    = 3'd3;
  localparam logic [OpW-1:0] OP_ARB_RESUME  = 3'd4;
  localparam logic [OpW-1:0] OP_ERROR       = 3'd5;
  localparam logic [OpW-1:0] OP_BONUS       = 3'd6;
  localparam logic [OpW-1:0] OP_PENALTY     = 3'd7;

  localparam logic [StatW-1:0] ST_PAUSED    = 3'd0;
  localparam logic [StatW-1:0] ST_RUNNING   = 3'd1;
  localparam logic [StatW-1:0] ST_STOPPED   = 3'd2;
  localparam logic [StatW-1:0] ST_LEFT_WON  = 3'd3;
  localparam logic [StatW-1:0] ST_RIGHT_WON = 3'd4;

  localparam logic [0:0] SIDE_LEFT  = 1'b0;
  localparam logic [0:0] SIDE_RIGHT = 1'b1;

  typedef struct packed {
    logic [StatW-1:0]  status;
    logic              side;
    logic [TimeW-1:0]  left_ms;
    logic [TimeW-1:0]  right_ms;
    logic [MovesW-1:0] moves;
    logic [ErrW-1:0]   left_err;
    logic [ErrW-1:0]   right_err;
  } gpc_state_t;

  function automatic logic [TimeW-1:0] sat_add(input logic [TimeW-1:0] a,
                                               input logic [TimeW-1:0] b);
    logic [TimeW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[TimeW] ? '1 : sum[TimeW-1:0];
  endfunction

  function automatic logic [TimeW-1:0] sat_sub(input logic [TimeW-1:0] a,
                                               input logic [TimeW-1:0] b);
    return (b >= a) ? '0 : a - b;
  endfunction

endpackage

### design/gpc_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Game clock event step
// Next clock state from the current state and one registered event.
// ----------------------------------------------------------------------------
module gpc_step import gpc_pkg::*; (
  input  gpc_state_t       cur_i,
  input  logic [OpW-1:0]   operation_i,
  input  logic             side_i,
  input  logic [TimeW-1:0] amount_ms_i,
  input  logic             restart_i,
  input  logic [TimeW-1:0] start_time_ms_i,
  input  logic [TimeW-1:0] incr_ms_i,
  output gpc_state_t       nxt_o
);

  logic [TimeW-1:0] own_ms;
  logic [TimeW-1:0] act_ms;
  logic [TimeW-1:0] own_upd;
  logic [ErrW-1:0]  err_cnt;
  logic [ErrW-1:0]  err_inc;
  logic             running;

  assign running = (cur_i.status == ST_RUNNING);
  assign own_ms  = side_i ? cur_i.right_ms : cur_i.left_ms;
  assign act_ms  = cur_i.side ? cur_i.right_ms : cur_i.left_ms;
  assign err_cnt = side_i ? cur_i.right_err : cur_i.left_err;
  assign err_inc = (err_cnt == '1) ? err_cnt : err_cnt + ErrW'(1);

  always_comb begin
    nxt_o   = cur_i;
    own_upd = own_ms;
    if (restart_i) begin
      nxt_o.status    = ST_PAUSED;
      nxt_o.side      = SIDE_LEFT;
      nxt_o.left_ms   = start_time_ms_i;
      nxt_o.right_ms  = start_time_ms_i;
      nxt_o.moves     = '0;
      nxt_o.left_err  = '0;
      nxt_o.right_err = '0;
    end else begin
      case (operation_i)
        OP_TICK: begin
          if (running) begin
            if (amount_ms_i >= act_ms) begin
              if (cur_i.side) nxt_o.right_ms = '0;
              else            nxt_o.left_ms  = '0;
              nxt_o.status = cur_i.side ? ST_LEFT_WON : ST_RIGHT_WON;
            end else begin
              if (cur_i.side) nxt_o.right_ms = act_ms - amount_ms_i;
              else            nxt_o.left_ms  = act_ms - amount_ms_i;
            end
          end
        end
        OP_PRESS: begin
          if (running && (side_i == cur_i.side)) begin
            own_upd    = sat_add(own_ms, incr_ms_i);
            nxt_o.side = ~cur_i.side;
            if (cur_i.moves != '1) nxt_o.moves = cur_i.moves + MovesW'(1);
          end
        end
        OP_PAUSE: begin
          if (cur_i.status == ST_PAUSED)   nxt_o.status = ST_RUNNING;
          else if (running)                nxt_o.status = ST_PAUSED;
        end
        OP_ARB_STOP: begin
          if ((cur_i.status == ST_PAUSED) || running) nxt_o.status = ST_STOPPED;
        end
        OP_ARB_RESUME: begin
          if (cur_i.status == ST_STOPPED) nxt_o.status = ST_PAUSED;
        end
        OP_ERROR: begin
          if (side_i) nxt_o.right_err = err_inc;
          else        nxt_o.left_err  = err_inc;
          if (err_inc >= ERROR_LIMIT) nxt_o.status = side_i ? ST_LEFT_WON : ST_RIGHT_WON;
        end
        OP_BONUS: begin
          own_upd = sat_add(own_ms, amount_ms_i);
        end
        OP_PENALTY: begin
          own_upd = sat_sub(own_ms, amount_ms_i);
        end
        default: begin
          own_upd = own_ms;
        end
      endcase
      if ((operation_i == OP_BONUS) || (operation_i == OP_PENALTY) ||
          (operation_i == OP_PRESS)) begin
        if (side_i) nxt_o.right_ms = own_upd;
        else        nxt_o.left_ms  = own_upd;
      end
    end
  end

endmodule

### design/two_player_game_clock_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-player game clock core
// Countdown clock with Fischer increment, arbiter control and error limit.
// ----------------------------------------------------------------------------
// Each event transfer lands in an input register; the event logic then updates
// the clock state register, also the status output register, when the status
// side can take it, and one event per cycle is sustained while the status side
// keeps up. Every event returns one status transfer. The user must write the
// start time (index 0) and the per-move increment (index 1) only while no
// event is in flight; the block itself does not enforce it.
module two_player_game_clock_core import gpc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [TimeW-1:0]  cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [OpW-1:0]    operation_i,
  input  logic              side_i,
  input  logic [TimeW-1:0]  amount_ms_i,
  input  logic              restart_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [StatW-1:0]  clock_status_o,
  output logic              active_side_o,
  output logic [TimeW-1:0]  left_time_ms_o,
  output logic [TimeW-1:0]  right_time_ms_o,
  output logic [MovesW-1:0] moves_made_o,
  output logic [ErrW-1:0]   left_errors_o,
  output logic [ErrW-1:0]   right_errors_o
);

  logic [TimeW-1:0] start_time_q;
  logic [TimeW-1:0] increment_q;

  logic             ev_valid_q;
  logic [OpW-1:0]   ev_op_q;
  logic             ev_side_q;
  logic [TimeW-1:0] ev_amount_q;
  logic             ev_restart_q;

  logic             out_valid_q;
  gpc_state_t       state_q;
  gpc_state_t       state_d;
  logic             advance;
  logic             in_xfer;

  assign advance    = ev_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !ev_valid_q || !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_time_q <= START_TIME_RST;
      increment_q  <= INCREMENT_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i) increment_q  <= cfg_data_i;
      else             start_time_q <= cfg_data_i;
    end
  end

  // hold the event until the status register takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_valid_q <= 1'b0;
    end else if (in_xfer) begin
      ev_valid_q <= 1'b1;
    end else if (advance) begin
      ev_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      ev_op_q      <= operation_i;
      ev_side_q    <= side_i;
      ev_amount_q  <= amount_ms_i;
      ev_restart_q <= restart_i;
    end
  end

  gpc_step u_step (
    .cur_i          (state_q),
    .operation_i    (ev_op_q),
    .side_i         (ev_side_q),
    .amount_ms_i    (ev_amount_q),
    .restart_i      (ev_restart_q),
    .start_time_ms_i(start_time_q),
    .incr_ms_i      (increment_q),
    .nxt_o          (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q       <= 1'b0;
      state_q.status    <= ST_PAUSED;
      state_q.side      <= SIDE_LEFT;
      state_q.left_ms   <= START_TIME_RST;
      state_q.right_ms  <= START_TIME_RST;
      state_q.moves     <= '0;
      state_q.left_err  <= '0;
      state_q.right_err <= '0;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign clock_status_o  = state_q.status;
  assign active_side_o   = state_q.side;
  assign left_time_ms_o  = state_q.left_ms;
  assign right_time_ms_o = state_q.right_ms;
  assign moves_made_o    = state_q.moves;
  assign left_errors_o   = state_q.left_err;
  assign right_errors_o  = state_q.right_err;

`ifndef SYNTHESIS
  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && ev_restart_q |=> (state_q.moves == '0) && (state_q.left_err == '0) &&
      (state_q.right_err == '0) && (state_q.status == ST_PAUSED))
    else $error("restart did not clear the clock state");

  a_moves_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !ev_restart_q |=> state_q.moves >= $past(state_q.moves))
    else $error("move count decreased without restart");

  a_win_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !ev_restart_q &&
      ((state_q.status == ST_LEFT_WON) || (state_q.status == ST_RIGHT_WON))
    |=> (state_q.status == ST_LEFT_WON) || (state_q.status == ST_RIGHT_WON))
    else $error("finished game left its won status");

  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("clock state changed without an event");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ev_valid_q |-> in_ready_o)
    else $error("input stalled with an empty event register");
`endif

endmodule

### sim/tb_two_player_game_clock_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-player game clock core testbench
// Drives clock events over a valid/ready channel and checks each status
// transfer against an in-bench prediction of the clock. Covers the
// ignored-event cases, time-out and error-limit losses, saturation of time
// and error counts, and several start/increment settings, with random
// sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module tb_two_player_game_clock_core import gpc_pkg::*;;

  localparam logic        CFG_START_TIME = 1'b0;
  localparam logic        CFG_INCREMENT  = 1'b1;
  localparam int unsigned CYCLE_LIMIT    = 5_000_000;

  class game_clock_scoreboard;
    logic [TimeW-1:0]  reload_ms;
    logic [TimeW-1:0]  inc_ms;
    logic [TimeW-1:0]  left_ms;
    logic [TimeW-1:0]  right_ms;
    logic [ErrW-1:0]   left_err;
    logic [ErrW-1:0]   right_err;
    logic              side;
    logic [StatW-1:0]  status;
    logic [MovesW-1:0] moves;
    gpc_state_t        status_q[$];
    int unsigned       n_fail;

    function new();
      reload_ms = START_TIME_RST;
      inc_ms    = INCREMENT_RST;
      n_fail    = 0;
      reload();
    endfunction

    function void reload();
      left_ms   = reload_ms;
      right_ms  = reload_ms;
      left_err  = '0;
      right_err = '0;
      side      = SIDE_LEFT;
      status    = ST_PAUSED;
      moves     = '0;
    endfunction

    function logic [TimeW-1:0] add_clamp(input logic [TimeW-1:0] a, input logic [TimeW-1:0] b);
      logic [TimeW:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[TimeW] ? '1 : sum[TimeW-1:0];
    endfunction

    function int unsigned outstanding();
      return status_q.size();
    endfunction

    // advance the clock by one accepted event and queue the status it yields
    function void note_event(input logic [OpW-1:0] op, input logic sd,
                             input logic [TimeW-1:0] amount, input logic rs);
      gpc_state_t exp;
      if (rs) begin
        reload();
      end else begin
        case (op)
          OP_TICK: begin
            if (status == ST_RUNNING) begin
              if (side == SIDE_RIGHT) begin
                if (amount >= right_ms) begin
                  right_ms = '0;
                  status   = ST_LEFT_WON;
                end else begin
                  right_ms = right_ms - amount;
                end
              end else begin
                if (amount >= left_ms) begin
                  left_ms = '0;
                  status  = ST_RIGHT_WON;
                end else begin
                  left_ms = left_ms - amount;
                end
              end
            end
          end
          OP_PRESS: begin
            if (status == ST_RUNNING && sd == side) begin
              if (sd == SIDE_RIGHT) right_ms = add_clamp(right_ms, inc_ms);
              else left_ms = add_clamp(left_ms, inc_ms);
              side = ~side;
              if (moves != '1) moves = moves + MovesW'(1);
            end
          end
          OP_PAUSE: begin
            if (status == ST_PAUSED) status = ST_RUNNING;
            else if (status == ST_RUNNING) status = ST_PAUSED;
          end
          OP_ARB_STOP: begin
            if (status == ST_PAUSED || status == ST_RUNNING) status = ST_STOPPED;
          end
          OP_ARB_RESUME: begin
            if (status == ST_STOPPED) status = ST_PAUSED;
          end
          OP_ERROR: begin
            if (sd == SIDE_RIGHT) begin
              if (right_err != '1) right_err = right_err + ErrW'(1);
              if (right_err >= ERROR_LIMIT) status = ST_LEFT_WON;
            end else begin
              if (left_err != '1) left_err = left_err + ErrW'(1);
              if (left_err >= ERROR_LIMIT) status = ST_RIGHT_WON;
            end
          end
          OP_BONUS: begin
            if (sd == SIDE_RIGHT) right_ms = add_clamp(right_ms, amount);
            else left_ms = add_clamp(left_ms, amount);
          end
          default: begin
            if (sd == SIDE_RIGHT) right_ms = (amount >= right_ms) ? '0 : right_ms - amount;
            else left_ms = (amount >= left_ms) ? '0 : left_ms - amount;
          end
        endcase
      end
      exp = '{status, side, left_ms, right_ms, moves, left_err, right_err};
      status_q.push_back(exp);
    endfunction

    function void compare_field(input string name, input logic [TimeW-1:0] exp_val,
                                input logic [TimeW-1:0] act_val);
      if (exp_val !== act_val) begin
        $error("%s: expected %0h, got %0h", name, exp_val, act_val);
        n_fail++;
      end
    endfunction

    function void check_status(input gpc_state_t got);
      gpc_state_t exp;
      if (status_q.size() == 0) begin
        $error("status transfer with no event outstanding");
        n_fail++;
        return;
      end
      exp = status_q.pop_front();
      compare_field("clock_status", TimeW'(exp.status), TimeW'(got.status));
      compare_field("active_side", TimeW'(exp.side), TimeW'(got.side));
      compare_field("left_time_ms", exp.left_ms, got.left_ms);
      compare_field("right_time_ms", exp.right_ms, got.right_ms);
      compare_field("moves_made", TimeW'(exp.moves), TimeW'(got.moves));
      compare_field("left_errors", TimeW'(exp.left_err), TimeW'(got.left_err));
      compare_field("right_errors", TimeW'(exp.right_err), TimeW'(got.right_err));
    endfunction
  endclass

  logic              clk_i           = 1'b0;
  logic              rst_ni          = 1'b0;
  logic              cfg_we_i        = 1'b0;
  logic              cfg_index_i     = CFG_START_TIME;
  logic [TimeW-1:0]  cfg_data_i      = '0;
  logic              in_valid_i      = 1'b0;
  logic              in_ready_o;
  logic [OpW-1:0]    operation_i     = OP_TICK;
  logic              side_i          = SIDE_LEFT;
  logic [TimeW-1:0]  amount_ms_i     = '0;
  logic              restart_i       = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i     = 1'b0;
  logic [StatW-1:0]  clock_status_o;
  logic              active_side_o;
  logic [TimeW-1:0]  left_time_ms_o;
  logic [TimeW-1:0]  right_time_ms_o;
  logic [MovesW-1:0] moves_made_o;
  logic [ErrW-1:0]   left_errors_o;
  logic [ErrW-1:0]   right_errors_o;

  game_clock_scoreboard sb = new();

  int unsigned cycle_cnt   = 0;
  int unsigned stall_left  = 0;
  int unsigned stall_mode  = 0;
  int unsigned beat_cnt    = 0;

  two_player_game_clock_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .side_i         (side_i),
    .amount_ms_i    (amount_ms_i),
    .restart_i      (restart_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .clock_status_o (clock_status_o),
    .active_side_o  (active_side_o),
    .left_time_ms_o (left_time_ms_o),
    .right_time_ms_o(right_time_ms_o),
    .moves_made_o   (moves_made_o),
    .left_errors_o  (left_errors_o),
    .right_errors_o (right_errors_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // check status transfers; stall on a changing pattern
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_status({clock_status_o, active_side_o, left_time_ms_o, right_time_ms_o,
                       moves_made_o, left_errors_o, right_errors_o});
    end
    beat_cnt <= beat_cnt + 1;
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(32, 400);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= 1'($urandom_range(0, 1));
      2: out_ready_i <= (beat_cnt % 4 == 0);
      default: out_ready_i <= ($urandom_range(0, 7) != 0);
    endcase
  end

  task automatic send_event(input logic [OpW-1:0] op, input logic sd,
                            input logic [TimeW-1:0] amt, input logic rs);
    operation_i <= op;
    side_i      <= sd;
    amount_ms_i <= amt;
    restart_i   <= rs;
    in_valid_i  <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_event(op, sd, amt, rs);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // drain, load both registers, then restart so the new start time applies
  task automatic next_setting(input logic [TimeW-1:0] start_val,
                              input logic [TimeW-1:0] inc_val);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_START_TIME;
    cfg_data_i  <= start_val;
    @(posedge clk_i);
    cfg_index_i <= CFG_INCREMENT;
    cfg_data_i  <= inc_val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.reload_ms = start_val;
    sb.inc_ms    = inc_val;
    send_event(OP_TICK, SIDE_LEFT, '0, 1'b1);
  endtask

  function automatic logic [TimeW-1:0] pick_amount();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return '0;
    if (roll < 16) return '1;
    if (roll < 30) return $urandom;
    return $urandom_range(0, 2000);
  endfunction

  // bias towards playable games: start paused games, restart finished ones
  task automatic random_event();
    logic [OpW-1:0]   op;
    logic             sd;
    logic [TimeW-1:0] amt;
    logic             rs;
    logic [TimeW-1:0] act_ms;
    int unsigned      roll;
    roll   = $urandom_range(0, 99);
    op     = OpW'($urandom_range(0, 7));
    sd     = 1'($urandom_range(0, 1));
    amt    = pick_amount();
    rs     = 1'b0;
    act_ms = (sb.side == SIDE_RIGHT) ? sb.right_ms : sb.left_ms;
    if (roll < 3) begin
      rs = 1'b1;
    end else begin
      case (sb.status)
        ST_PAUSED: if (roll < 55) op = OP_PAUSE;
        ST_STOPPED: if (roll < 50) op = OP_ARB_RESUME;
        ST_LEFT_WON, ST_RIGHT_WON: if (roll < 35) rs = 1'b1;
        default: begin
          if (roll < 45) begin
            op = OP_TICK;
            if (roll < 8) amt = act_ms;
            else if (roll < 11) amt = act_ms - TimeW'(1);
            else amt = $urandom_range(0, 1500);
          end else if (roll < 82) begin
            op = OP_PRESS;
            if (roll < 78) sd = sb.side;
          end
        end
      endcase
    end
    send_event(op, sd, amt, rs);
  endtask

  task automatic run_random(input int unsigned n_items);
    int unsigned burst;
    burst = 0;
    repeat (n_items) begin
      if (burst == 0) begin
        burst = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
        if ($urandom_range(0, 3) != 0) begin
          in_valid_i <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk_i);
        end
      end
      random_event();
      burst--;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_event(OP_TICK, SIDE_LEFT, '1, 1'b0);
    send_event(OP_PRESS, SIDE_LEFT, '0, 1'b0);
    send_event(OP_PAUSE, SIDE_LEFT, '0, 1'b0);
    send_event(OP_TICK, SIDE_RIGHT, 32'd1000, 1'b0);
    send_event(OP_PRESS, SIDE_RIGHT, '0, 1'b0);
    send_event(OP_PRESS, SIDE_LEFT, '0, 1'b0);
    send_event(OP_BONUS, SIDE_RIGHT, '1, 1'b0);
    send_event(OP_TICK, SIDE_LEFT, 32'd5, 1'b0);
    send_event(OP_PRESS, SIDE_RIGHT, '0, 1'b0);
    send_event(OP_PENALTY, SIDE_LEFT, '1, 1'b0);
    send_event(OP_TICK, SIDE_LEFT, '0, 1'b0);
    send_event(OP_ERROR, SIDE_LEFT, '0, 1'b0);
    send_event(OP_ERROR, SIDE_LEFT, '0, 1'b0);
    send_event(OP_PAUSE, SIDE_LEFT, '0, 1'b0);
    send_event(OP_ARB_STOP, SIDE_LEFT, '0, 1'b0);
    send_event(OP_ARB_RESUME, SIDE_LEFT, '0, 1'b0);
    send_event(OP_ERROR, SIDE_RIGHT, '1, 1'b1);
    send_event(OP_ARB_STOP, SIDE_LEFT, '0, 1'b0);
    send_event(OP_PAUSE, SIDE_LEFT, '0, 1'b0);
    send_event(OP_TICK, SIDE_LEFT, 32'd7, 1'b0);
    send_event(OP_ARB_RESUME, SIDE_LEFT, '0, 1'b0);
    send_event(OP_PAUSE, SIDE_LEFT, '0, 1'b0);
    send_event(OP_ARB_STOP, SIDE_LEFT, '0, 1'b0);
    send_event(OP_ERROR, SIDE_RIGHT, '0, 1'b0);
    send_event(OP_ERROR, SIDE_RIGHT, '0, 1'b0);

    next_setting('0, '1);
    run_random(200);
    next_setting('1, '0);
    run_random(200);
    next_setting(32'd20000, 32'd1500);
    run_random(250);
    next_setting($urandom, $urandom);
    run_random(200);
    next_setting(32'd5000, 32'hFFFF_FFFC);
    run_random(150);

    // run error counts into saturation
    next_setting(32'd1000, '0);
    send_event(OP_PAUSE, SIDE_LEFT, '0, 1'b0);
    repeat (260) send_event(OP_ERROR, SIDE_LEFT, $urandom, 1'b0);
    repeat (258) send_event(OP_ERROR, SIDE_RIGHT, $urandom, 1'b0);

    drain();
    if (sb.n_fail == 0 && sb.outstanding() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
